FILE: hw/rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

	// Fixed widths of the word fields
	localparam int OP_W        = 2;
	localparam int CHAR_W      = 8;
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;
	localparam int CELL_W      = 16;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 32;

	// Character codes handled by a put
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	// Attribute used for blanks at power-up, also the colour register reset
	localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} tcw_op_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;     // take in a new word
		logic exec;        // handle the captured word
		logic cnt_clr;
		logic cnt_inc;
		logic copy_step;   // one step of the scroll copy
		logic fill_step;   // write a blank at the sweep counter
		logic fill_reset;  // blank with the power-up attribute
		logic out_load;    // load the result register
	} tcw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		tcw_op_t op;
		logic    need_scroll;
		logic    copy_end;
		logic    last_cell;
		logic    out_free;
	} tcw_sts_t;

endpackage

FILE: hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tcw_pkg::tcw_sts_t  sts,
	output tcw_pkg::tcw_cmd_t  cmd
);
	import tcw_pkg::*;

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_COPY  = 7'b0001000,
		ST_FILL  = 7'b0010000,
		ST_CLEAR = 7'b0100000,
		ST_DONE  = 7'b1000000
	} tcw_state_t;

	tcw_state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill_step  = 1'b1;
				cmd.fill_reset = 1'b1;
				if (sts.last_cell) state_d = ST_IDLE;
				else cmd.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				unique case (sts.op)
					OP_PUT: begin
						if (sts.need_scroll) begin
							cmd.cnt_clr = 1'b1;
							state_d     = ST_COPY;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_CLEAR;
					end
					OP_READ, OP_NONE: state_d = ST_DONE;
					default:          state_d = ST_DONE;
				endcase
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_end) state_d = ST_FILL;
				else cmd.cnt_inc = 1'b1;
			end
			ST_FILL, ST_CLEAR: begin
				cmd.fill_step = 1'b1;
				if (sts.last_cell) state_d = ST_DONE;
				else cmd.cnt_inc = 1'b1;
			end
			ST_DONE: begin
				// hand over the result, and take the next word in the same cycle
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.capture = 1'b1;
						state_d     = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

endmodule

FILE: hw/rtl/tcw_datapath.sv
// Datapath: screen store, cursor, colour register, sweep counter, result register.
module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tcw_pkg::tcw_op_t                     in_op,
	input  logic [tcw_pkg::CHAR_W-1:0]           in_char,
	input  logic [tcw_pkg::ROW_FIELD_W-1:0]      in_row,
	input  logic [tcw_pkg::COL_FIELD_W-1:0]      in_col,
	input  logic                                 cfg_wen,
	input  logic [tcw_pkg::CHAR_W-1:0]           cfg_wdata,
	input  tcw_pkg::tcw_cmd_t                    cmd,
	output tcw_pkg::tcw_sts_t                    sts,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [tcw_pkg::OUT_DATA_W-1:0]       out_data
);
	import tcw_pkg::*;

	localparam int CELLS        = ROWS * COLUMNS;
	localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
	localparam int ADDR_W       = $clog2(CELLS);
	localparam int COL_W        = $clog2(COLUMNS);
	localparam int ROW_W        = $clog2(ROWS);
	localparam int WIDE_W       = ROW_FIELD_W + COL_FIELD_W;

	// Captured word
	tcw_op_t                  op_q;
	logic [CHAR_W-1:0]        char_q;
	logic [ROW_FIELD_W-1:0]   rrow_q;
	logic [COL_FIELD_W-1:0]   rcol_q;

	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         line_q;
	logic [CHAR_W-1:0]        color_q;
	logic [ADDR_W-1:0]        cnt_q;
	logic [CELL_W-1:0]        rd_q;
	logic                     scr_q;
	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;

	logic [CELL_W-1:0]        mem [CELLS];

	logic [COL_W-1:0]         col_n;
	logic [ROW_W:0]           line_n;
	logic [ROW_W-1:0]         line_fin;
	logic [COL_W-1:0]         put_col;
	logic                     put_we;
	logic [CELL_W-1:0]        put_data;
	logic [CELL_W-1:0]        blank;
	logic                     need_scroll;
	logic                     read_ok;
	logic [WIDE_W-1:0]        put_wide;
	logic [WIDE_W-1:0]        read_wide;
	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [CELL_W-1:0]        wdata;
	logic                     re;
	logic [ADDR_W-1:0]        raddr;
	logic [CELL_W-1:0]        rd_cell;

	assign blank = {(cmd.fill_reset ? RESET_COLOR : color_q), BLANK_CHAR};

	// Cursor movement for a put
	always_comb begin
		col_n    = col_q;
		line_n   = {1'b0, line_q};
		put_col  = col_q;
		put_we   = 1'b0;
		put_data = {color_q, char_q};
		priority if (char_q == CH_NEWLINE) begin
			col_n  = '0;
			line_n = {1'b0, line_q} + 1'b1;
		end else if (char_q == CH_RETURN) begin
			col_n = '0;
		end else if (char_q == CH_BACKSPACE) begin
			if (col_q != '0) begin
				col_n    = col_q - 1'b1;
				put_col  = col_q - 1'b1;
				put_we   = 1'b1;
				put_data = blank;
			end
		end else begin
			put_we = 1'b1;
			if (col_q == COL_W'(COLUMNS - 1)) begin
				col_n  = '0;
				line_n = {1'b0, line_q} + 1'b1;
			end else begin
				col_n = col_q + 1'b1;
			end
		end
	end

	assign need_scroll = (op_q == OP_PUT) && (line_n == (ROW_W + 1)'(ROWS));
	assign line_fin    = need_scroll ? ROW_W'(ROWS - 1) : line_n[ROW_W-1:0];

	// Cell addresses
	assign put_wide  = WIDE_W'(line_q) * WIDE_W'(COLUMNS) + WIDE_W'(put_col);
	assign read_wide = WIDE_W'(rrow_q) * WIDE_W'(COLUMNS) + WIDE_W'(rcol_q);
	assign read_ok   = ({1'b0, rrow_q} < (ROW_FIELD_W + 1)'(ROWS)) &&
	                   ({1'b0, rcol_q} < (COL_FIELD_W + 1)'(COLUMNS));

	// Store port selection
	always_comb begin
		we    = 1'b0;
		waddr = put_wide[ADDR_W-1:0];
		wdata = put_data;
		if (cmd.exec && (op_q == OP_PUT) && put_we) begin
			we = 1'b1;
		end else if (cmd.copy_step && (cnt_q != '0)) begin
			we    = 1'b1;
			waddr = cnt_q - 1'b1;
			wdata = rd_q;
		end else if (cmd.fill_step) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = blank;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = read_wide[ADDR_W-1:0];
		if (cmd.exec && (op_q == OP_READ) && read_ok) begin
			re = 1'b1;
		end else if (cmd.copy_step && !sts.copy_end) begin
			re    = 1'b1;
			raddr = cnt_q + ADDR_W'(COLUMNS);
		end
	end

	// Screen store
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// Captured word and scroll flag
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			char_q <= in_char;
			rrow_q <= in_row;
			rcol_q <= in_col;
		end
		if (cmd.exec) scr_q <= need_scroll;
	end

	// Cursor, colour and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			line_q  <= '0;
			color_q <= RESET_COLOR;
			cnt_q   <= '0;
		end else begin
			if (cfg_wen) color_q <= cfg_wdata;
			if (cmd.exec && (op_q == OP_PUT)) begin
				col_q  <= col_n;
				line_q <= line_fin;
			end else if (cmd.exec && (op_q == OP_CLEAR)) begin
				col_q  <= '0;
				line_q <= '0;
			end
			if (cmd.cnt_clr) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Result register
	assign rd_cell = ((op_q == OP_READ) && read_ok) ? rd_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {3'b000, scr_q, rd_cell,
			               ROW_FIELD_W'(line_q), COL_FIELD_W'(col_q)};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Status back to the controller
	assign sts.op          = op_q;
	assign sts.need_scroll = need_scroll;
	assign sts.copy_end    = (cnt_q == ADDR_W'(SCROLL_CELLS));
	assign sts.last_cell   = (cnt_q == ADDR_W'(CELLS - 1));
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

FILE: hw/rtl/text_console_writer_unit.sv
// Text console writer: top level joining controller and datapath.
//
// Input channel s_axis: one word per command. tuser carries the operation
// (put character, clear screen, read cell); tdata carries the character and
// the row and column of a read. Output channel m_axis: one result word per
// command with the cursor after the command, the cell read (zero for other
// operations) and a flag set when the command scrolled the screen. Write the
// colour register (cfg_wen/cfg_wdata) only while the block is idle (unenforced).
//
// A put without scroll, a read and an unused operation pass through the exec
// and done states to the result register; the next command is taken when the
// result is loaded. A scroll walks the store through its single write port:
// it copies rows up, then blanks the bottom row. A clear blanks all cells.
// After reset the block blanks the whole store (attribute 0x0F, space) one
// cell a cycle, with s_axis_tready low; cursor goes home. A finished result
// waits in the output register while the next command is accepted and worked
// on; that command holds in its last state until the receiver takes the
// waiting word.
module text_console_writer_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
	input  logic [tcw_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// [1:0] operation
	input  logic [tcw_pkg::OP_W-1:0]            s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [6:0] cursor_col, [11:7] cursor_row, [27:12] cell_data, [28] scrolled,
	// [31:29] zero
	output logic [tcw_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_wen,
	input  logic [tcw_pkg::CHAR_W-1:0]          cfg_wdata
);
	import tcw_pkg::*;

	tcw_cmd_t cmd;
	tcw_sts_t sts;
	tcw_op_t  in_op;

	assign in_op = tcw_op_t'(s_axis_tuser);

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (in_op),
		.in_char   (s_axis_tdata[7:0]),
		.in_row    (s_axis_tdata[12:8]),
		.in_col    (s_axis_tdata[19:13]),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	// A word just taken is being worked on, so no second word next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on two consecutive cycles");

	// A scroll leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[28] |->
			(m_axis_tdata[11:7] == ROW_FIELD_W'(ROWS - 1)) &&
			(m_axis_tdata[6:0] == '0))
		else $error("scroll result with cursor off the bottom row start");

	// Reported cursor always lies on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			({1'b0, m_axis_tdata[6:0]} < (COL_FIELD_W + 1)'(COLUMNS)) &&
			({1'b0, m_axis_tdata[11:7]} < (ROW_FIELD_W + 1)'(ROWS)))
		else $error("cursor outside the screen");

endmodule

FILE: tb/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: predictor, stream driver, checker.
module text_console_writer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = ROWS * COLUMNS;
	localparam int CLK_PERIOD  = 8;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD   = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		tcw_op_t                 op;
		logic [CHAR_W-1:0]       ch;
		logic [ROW_FIELD_W-1:0]  rr;
		logic [COL_FIELD_W-1:0]  rc;
	} console_cmd_t;

	typedef struct packed {
		logic [COL_FIELD_W-1:0]  col;
		logic [ROW_FIELD_W-1:0]  row;
		logic [CELL_W-1:0]       cell_data;
		logic                    scrolled;
	} cursor_report_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic [OP_W-1:0]         s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic                    cfg_wen = 1'b0;
	logic [CHAR_W-1:0]       cfg_wdata = '0;

	// Shadow copy of the screen, cursor and colour register
	logic [CELL_W-1:0]       shadow_screen [0:CELLS-1];
	int                      shadow_col;
	int                      shadow_row;
	logic [CHAR_W-1:0]       shadow_colour;

	console_cmd_t            cmd_backlog[$];
	cursor_report_t          report_due[$];
	int                      faults = 0;

	// Sender and receiver pacing
	console_cmd_t            tx_cmd;
	int                      tx_gap = 0;
	int                      tx_burst = 0;
	int                      rx_wait = 0;
	int                      rx_burst = 0;
	bit                      hold_req = 1'b0;
	bit                      hold_taken = 1'b0;
	int                      hold_left = 0;
	int                      idle_cycles = 0;

	text_console_writer_unit #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Apply one command to the shadow screen and return the word it should produce
	function automatic cursor_report_t console_step(input console_cmd_t cmd);
		cursor_report_t     rep;
		logic [CELL_W-1:0]  blank;
		int                 i;
		rep   = '0;
		blank = {shadow_colour, BLANK_CHAR};
		case (cmd.op)
			OP_PUT: begin
				if (cmd.ch == CH_NEWLINE) begin
					shadow_col = 0;
					shadow_row++;
				end else if (cmd.ch == CH_RETURN) begin
					shadow_col = 0;
				end else if (cmd.ch == CH_BACKSPACE) begin
					if (shadow_col > 0) begin
						shadow_col--;
						shadow_screen[shadow_row * COLUMNS + shadow_col] = blank;
					end
				end else begin
					shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_colour, cmd.ch};
					shadow_col++;
					if (shadow_col >= COLUMNS) begin
						shadow_col = 0;
						shadow_row++;
					end
				end
				// moved off the bottom: shift everything up one row
				if (shadow_row >= ROWS) begin
					for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
						shadow_screen[i] = shadow_screen[i + COLUMNS];
					for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
						shadow_screen[i] = blank;
					shadow_row   = ROWS - 1;
					rep.scrolled = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					shadow_screen[i] = blank;
				shadow_col = 0;
				shadow_row = 0;
			end
			OP_READ: begin
				if (cmd.rr < ROWS && cmd.rc < COLUMNS)
					rep.cell_data = shadow_screen[cmd.rr * COLUMNS + cmd.rc];
			end
			default: ;
		endcase
		rep.col = shadow_col[COL_FIELD_W-1:0];
		rep.row = shadow_row[ROW_FIELD_W-1:0];
		return rep;
	endfunction

	// Compare a result word against the oldest outstanding prediction
	task automatic check_report(input logic [OUT_DATA_W-1:0] word);
		cursor_report_t want;
		cursor_report_t got;
		got.col       = word[6:0];
		got.row       = word[11:7];
		got.cell_data = word[27:12];
		got.scrolled  = word[28];
		if (report_due.size() == 0) begin
			faults++;
			if (faults <= MAX_REPORTS)
				$display("unexpected result word %h", word);
		end else begin
			want = report_due.pop_front();
			if (got.col !== want.col || got.row !== want.row ||
			    got.cell_data !== want.cell_data || got.scrolled !== want.scrolled) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display({"mismatch: expected col %0d row %0d cell %h scrolled %0b,",
						" got col %0d row %0d cell %h scrolled %0b"},
						want.col, want.row, want.cell_data, want.scrolled,
						got.col, got.row, got.cell_data, got.scrolled);
			end
		end
	endtask

	// Input driver: predict on acceptance, then offer the next word after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				report_due.push_back(console_step(tx_cmd));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					tx_cmd = cmd_backlog.pop_front();
					s_axis_tdata  <= {4'b0, tx_cmd.rc, tx_cmd.rr, tx_cmd.ch};
					s_axis_tuser  <= tx_cmd.op;
					s_axis_tvalid <= 1'b1;
					if (tx_burst > 0) begin
						tx_burst--;
						tx_gap = 0;
					end else begin
						tx_gap = $urandom_range(0, 10);
						if ($urandom_range(0, 19) == 0)
							tx_burst = $urandom_range(10, 50);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each word, then hold tready low for a drawn wait
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_report(m_axis_tdata);
				if (rx_burst > 0) begin
					rx_burst--;
					rx_wait = 0;
				end else begin
					rx_wait = $urandom_range(0, 10);
					if ($urandom_range(0, 19) == 0)
						rx_burst = $urandom_range(10, 50);
				end
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on stretches with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic add_cmd(input tcw_op_t op, input int ch, input int rr, input int rc);
		console_cmd_t cmd;
		cmd.op = op;
		cmd.ch = ch[CHAR_W-1:0];
		cmd.rr = rr[ROW_FIELD_W-1:0];
		cmd.rc = rc[COL_FIELD_W-1:0];
		cmd_backlog.push_back(cmd);
	endtask

	// Sender pause: wait until every word has gone through and been checked
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || s_axis_tvalid || report_due.size() != 0);
	endtask

	task automatic write_colour(input logic [CHAR_W-1:0] value);
		@(posedge clk);
		cfg_wen       <= 1'b1;
		cfg_wdata     <= value;
		shadow_colour  = value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Mostly runs of text with line endings, plus reads, clears and noise
	task automatic random_batch(input int count);
		int made;
		int len;
		int k;
		int ending;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 19))
				0: begin
					if ($urandom_range(0, 2) == 0) begin
						add_cmd(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 31),
							$urandom_range(0, 127));
						made++;
					end else begin
						add_cmd(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 31),
							$urandom_range(0, 127));
					end
				end
				1, 2: begin
					add_cmd(tcw_op_t'($urandom_range(0, 2)), $urandom_range(0, 255),
						$urandom_range(0, 31), $urandom_range(0, 127));
					made++;
				end
				3, 4, 5, 6, 7, 8: begin
					len = $urandom_range(1, 4);
					for (k = 0; k < len; k++) begin
						add_cmd(OP_READ, $urandom_range(0, 255),
							($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
							                            : $urandom_range(0, ROWS - 1),
							($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
							                            : $urandom_range(0, COLUMNS - 1));
						made++;
					end
				end
				default: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
					                                  : $urandom_range(1, 12);
					for (k = 0; k < len; k++) begin
						if ($urandom_range(0, 11) == 0)
							add_cmd(OP_PUT, CH_BACKSPACE, $urandom_range(0, 31),
								$urandom_range(0, 127));
						else if ($urandom_range(0, 9) == 0)
							add_cmd(OP_PUT, $urandom_range(0, 255), 0, 0);
						else
							add_cmd(OP_PUT, $urandom_range(32, 126), 0, 0);
						made++;
					end
					ending = $urandom_range(0, 9);
					if (ending == 4 || ending == 5) begin
						add_cmd(OP_PUT, CH_RETURN, 0, 0);
						made++;
					end
					if (ending <= 3 || ending == 5) begin
						add_cmd(OP_PUT, CH_NEWLINE, 0, 0);
						made++;
					end
				end
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			shadow_screen[i] = {RESET_COLOR, BLANK_CHAR};
		shadow_col    = 0;
		shadow_row    = 0;
		shadow_colour = RESET_COLOR;

		// Directed: power-up contents, field extremes and every control code
		add_cmd(OP_READ, 0, 0, 0);
		add_cmd(OP_READ, 255, ROWS - 1, COLUMNS - 1);
		add_cmd(OP_PUT, 8'h41, 31, 127);
		add_cmd(OP_PUT, 8'hFF, 0, 0);
		add_cmd(OP_PUT, 8'h00, 0, 0);
		add_cmd(OP_READ, 0, 0, 0);
		add_cmd(OP_READ, 0, 0, 2);
		add_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
		add_cmd(OP_READ, 0, 0, 2);
		add_cmd(OP_PUT, CH_RETURN, 0, 0);
		add_cmd(OP_PUT, CH_BACKSPACE, 0, 0);
		add_cmd(OP_READ, 0, 0, 0);
		add_cmd(OP_PUT, CH_NEWLINE, 0, 0);
		add_cmd(OP_PUT, 8'h7E, 0, 0);
		add_cmd(OP_READ, 0, 31, 127);
		add_cmd(OP_READ, 0, ROWS, 0);
		add_cmd(OP_READ, 0, 0, COLUMNS);
		add_cmd(OP_NONE, 255, 31, 127);
		add_cmd(OP_CLEAR, 255, 31, 127);
		add_cmd(OP_READ, 0, 1, 0);
		add_cmd(OP_READ, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// Random phases under different colours, extremes first
		write_colour(8'h00);
		random_batch(500);
		drain();

		// receiver holds off while the sender keeps offering
		write_colour(8'hFF);
		random_batch(500);
		hold_req = 1'b1;
		drain();

		write_colour(CHAR_W'($urandom_range(1, 254)));
		random_batch(500);
		drain();

		write_colour(CHAR_W'($urandom_range(0, 255)));
		random_batch(500);
		drain();

		repeat (20) @(posedge clk);
		if (faults == 0 && report_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
